// ===== hw/rtl/peg_pkg.sv =====
// ----------------------------------------------------------------------------
// peg_pkg
// Shared types and constants of the pluck envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package peg_pkg;

    localparam int PEG_SAMPLE_RATE = 44100;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATIO   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_MIX     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIME     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATIO    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_MIX      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SECONDS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH    = 4'd7;

    localparam logic [31:0] RST_ATTACK_TIME    = 32'd167772;
    localparam logic [31:0] RST_ATTACK_RATIO   = 32'd16777216;
    localparam logic [16:0] RST_ATTACK_MIX     = 17'd65536;
    localparam logic [31:0] RST_DECAY_TIME     = 32'd8388608;
    localparam logic [31:0] RST_DECAY_RATIO    = 32'd16777216;
    localparam logic [16:0] RST_DECAY_MIX      = 17'd65536;
    localparam logic [31:0] RST_LENGTH_SECONDS = 32'd16777216;
    localparam logic [31:0] RST_LOOP_LENGTH    = 32'd0;
    localparam logic [31:0] RST_PHASE_STEP     = 32'd429497;

    localparam logic [31:0] EXP_NEG_ONE = 32'd1580030169;
    localparam logic [63:0] EXP_LIMIT   = 64'd17 << 16;
    localparam logic [16:0] MIX_ONE     = 17'd65536;

    localparam int DIV_W = 64;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_N_PHASE  = 7'd48;
    localparam logic [DIV_CNT_W-1:0] DIV_N_TAYLOR = 7'd33;
    localparam logic [DIV_CNT_W-1:0] DIV_N_STEP   = 7'd64;

    localparam logic [3:0] TAYLOR_TERMS = 4'd10;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pluck_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// pluck_envelope_generator
// Pluck envelope: decay mix minus attack mix of decaying exponentials,
// one shared divider and one shared multiplier under a sequencer.
//
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    s_restart, s_length_mod
// m_       out        m_valid / m_ready    m_envelope
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word's time is set mostly by the bit-serial divider:
// four phase divisions, up to 40 taylor divisions,
// up to 64 exp(-1) multiplies, and a phase step division
// a length_seconds write holds both inputs until the phase step is recomputed
// reset is synchronous; no clearing pass
// a finished word waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module pluck_envelope_generator #(
    parameter int SAMPLE_RATE = peg_pkg::PEG_SAMPLE_RATE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_restart,
    input  wire logic signed [31:0]             s_length_mod,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [17:0]                  m_envelope,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [peg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [peg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import peg_pkg::*;

    localparam logic [63:0] STEP_NUM = 64'((64'd1 << 56) / 64'(SAMPLE_RATE));

    typedef enum logic [4:0] {
        S_IDLE, S_TSEL, S_TMUL_W, S_PDIV, S_PDIV_W, S_TAY_MUL, S_TAY_MUL_W,
        S_TAY_DIV_W, S_EXP_FIX, S_EXP_MUL, S_EXP_MUL_W, S_ROUND, S_STORE,
        S_MIX_A, S_MIX_A_W, S_MIX_B_W, S_ADV, S_OFF, S_STEP, S_STEP_W, S_OUT
    } state_t;

    state_t state_reg;

    logic [31:0] attack_time_reg, attack_ratio_reg, decay_time_reg, decay_ratio_reg;
    logic [16:0] attack_mix_reg, decay_mix_reg;
    logic [31:0] length_seconds_reg, loop_length_reg;

    logic [31:0]        phase_reg;
    logic signed [47:0] offset_reg;
    logic [31:0]        step_reg;

    logic signed [31:0] mod_reg;
    logic               item_reg;
    logic               wrap_reg;
    logic [1:0]         ti_reg;
    logic [39:0]        tcur_reg;
    logic [4:0]         nexp_reg;
    logic [31:0]        f_reg;
    logic [32:0]        term_reg;
    logic signed [34:0] sum_reg;
    logic [3:0]         k_reg;
    logic [32:0]        v_reg;
    logic [16:0]        ecur_reg, ea_reg, eb_reg;
    logic [34:0]        acc_reg;
    logic [16:0]        dmix_reg;
    logic signed [17:0] env_reg;
    logic               m_valid_reg;
    logic signed [17:0] m_env_reg;

    div_req_t         div_req_reg;
    logic [DIV_W-1:0] div_dvd_reg, div_dsr_reg;
    logic [DIV_W-1:0] div_q;
    div_stat_t        div_stat;

    logic        mul_start_reg;
    logic [32:0] mul_a_reg;
    logic [31:0] mul_b_reg;
    logic [64:0] mul_p;
    logic        mul_done;

    logic [31:0]        sel_time, sel_ratio;
    logic [16:0]        sel_mix, mix_m;
    logic [33:0]        rnd;
    logic [34:0]        mix_sum;
    logic signed [34:0] nx;
    logic [31:0]        nx_c;
    logic signed [47:0] off_base;
    logic signed [48:0] off_sum;
    logic signed [49:0] denom;

    peg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    peg_multiplier u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .prod    (mul_p),
        .done    (mul_done)
    );

    always_comb begin
        sel_time  = ti_reg[1] ? attack_time_reg : decay_time_reg;
        sel_ratio = ti_reg[1] ? attack_ratio_reg : decay_ratio_reg;
        sel_mix   = ti_reg[1] ? attack_mix_reg : decay_mix_reg;
        mix_m     = (sel_mix > MIX_ONE) ? MIX_ONE : sel_mix;
        rnd       = 34'(v_reg) + 34'd32768;
        mix_sum   = acc_reg + mul_p[34:0] + 35'd32768;
        nx        = $signed({3'b000, phase_reg}) + $signed({11'd0, step_reg[31:8]})
                  + 35'(mod_reg);
        if (nx < 0) begin
            nx_c = '0;
        end else if (nx[34:32] != 3'b000) begin
            nx_c = 32'hFFFF_FFFF;
        end else begin
            nx_c = nx[31:0];
        end
        off_base = wrap_reg ? 48'(mod_reg) : offset_reg;
        off_sum  = 49'(off_base) + 49'(mod_reg);
        denom    = 50'(offset_reg) + $signed({18'd0, length_seconds_reg});
    end

    assign s_ready    = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_envelope = m_env_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            attack_time_reg    <= RST_ATTACK_TIME;
            attack_ratio_reg   <= RST_ATTACK_RATIO;
            attack_mix_reg     <= RST_ATTACK_MIX;
            decay_time_reg     <= RST_DECAY_TIME;
            decay_ratio_reg    <= RST_DECAY_RATIO;
            decay_mix_reg      <= RST_DECAY_MIX;
            length_seconds_reg <= RST_LENGTH_SECONDS;
            loop_length_reg    <= RST_LOOP_LENGTH;
            phase_reg          <= '0;
            offset_reg         <= '0;
            step_reg           <= RST_PHASE_STEP;
            item_reg           <= 1'b0;
            ti_reg             <= '0;
            m_valid_reg        <= 1'b0;
            div_req_reg        <= '0;
            mul_start_reg      <= 1'b0;
        end else begin
            div_req_reg.start <= 1'b0;
            mul_start_reg     <= 1'b0;
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            REG_ATTACK_TIME:  attack_time_reg  <= cfg_data;
                            REG_ATTACK_RATIO: attack_ratio_reg <= cfg_data;
                            REG_ATTACK_MIX:   attack_mix_reg   <= cfg_data[16:0];
                            REG_DECAY_TIME:   decay_time_reg   <= cfg_data;
                            REG_DECAY_RATIO:  decay_ratio_reg  <= cfg_data;
                            REG_DECAY_MIX:    decay_mix_reg    <= cfg_data[16:0];
                            REG_LENGTH_SECONDS: begin
                                length_seconds_reg <= cfg_data;
                                item_reg           <= 1'b0;
                                state_reg          <= S_STEP;
                            end
                            REG_LOOP_LENGTH:  loop_length_reg  <= cfg_data;
                            default: ;
                        endcase
                    end else if (s_valid) begin
                        mod_reg  <= s_length_mod;
                        item_reg <= 1'b1;
                        ti_reg   <= '0;
                        if (s_restart) begin
                            phase_reg  <= '0;
                            offset_reg <= 48'(s_length_mod);
                        end
                        state_reg <= S_TSEL;
                    end
                end
                S_TSEL: begin
                    if (!ti_reg[0]) begin
                        tcur_reg  <= 40'(sel_time);
                        state_reg <= S_PDIV;
                    end else begin
                        mul_a_reg     <= {1'b0, sel_time};
                        mul_b_reg     <= sel_ratio;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_TMUL_W;
                    end
                end
                S_TMUL_W: begin
                    if (mul_done) begin
                        tcur_reg  <= mul_p[63:24];
                        state_reg <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (tcur_reg == '0) begin
                        ecur_reg  <= '0;
                        state_reg <= S_STORE;
                    end else begin
                        div_dvd_reg       <= {16'd0, phase_reg, 16'd0};
                        div_dsr_reg       <= {24'd0, tcur_reg};
                        div_req_reg.count <= DIV_N_PHASE;
                        div_req_reg.start <= 1'b1;
                        state_reg         <= S_PDIV_W;
                    end
                end
                S_PDIV_W: begin
                    if (div_stat.done) begin
                        if (div_q >= EXP_LIMIT) begin
                            ecur_reg  <= '0;
                            state_reg <= S_STORE;
                        end else begin
                            nexp_reg  <= div_q[20:16];
                            f_reg     <= {div_q[15:0], 16'd0};
                            term_reg  <= 33'h1_0000_0000;
                            sum_reg   <= 35'sh1_0000_0000;
                            k_reg     <= 4'd1;
                            state_reg <= S_TAY_MUL;
                        end
                    end
                end
                S_TAY_MUL: begin
                    mul_a_reg     <= term_reg;
                    mul_b_reg     <= f_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_TAY_MUL_W;
                end
                S_TAY_MUL_W: begin
                    if (mul_done) begin
                        div_dvd_reg       <= {31'd0, mul_p[64:32]};
                        div_dsr_reg       <= 64'(k_reg);
                        div_req_reg.count <= DIV_N_TAYLOR;
                        div_req_reg.start <= 1'b1;
                        state_reg         <= S_TAY_DIV_W;
                    end
                end
                S_TAY_DIV_W: begin
                    if (div_stat.done) begin
                        term_reg <= div_q[32:0];
                        if (k_reg[0]) begin
                            sum_reg <= sum_reg - $signed({2'b00, div_q[32:0]});
                        end else begin
                            sum_reg <= sum_reg + $signed({2'b00, div_q[32:0]});
                        end
                        if (k_reg == TAYLOR_TERMS) begin
                            state_reg <= S_EXP_FIX;
                        end else begin
                            k_reg     <= k_reg + 4'd1;
                            state_reg <= S_TAY_MUL;
                        end
                    end
                end
                S_EXP_FIX: begin
                    v_reg     <= (sum_reg < 0) ? 33'd0 : sum_reg[32:0];
                    state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL: begin
                    if (nexp_reg == '0) begin
                        state_reg <= S_ROUND;
                    end else begin
                        mul_a_reg     <= v_reg;
                        mul_b_reg     <= EXP_NEG_ONE;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_EXP_MUL_W;
                    end
                end
                S_EXP_MUL_W: begin
                    if (mul_done) begin
                        v_reg     <= mul_p[64:32];
                        nexp_reg  <= nexp_reg - 5'd1;
                        state_reg <= S_EXP_MUL;
                    end
                end
                S_ROUND: begin
                    ecur_reg  <= rnd[32:16];
                    state_reg <= S_STORE;
                end
                S_STORE: begin
                    if (!ti_reg[0]) begin
                        ea_reg    <= ecur_reg;
                        ti_reg    <= ti_reg + 2'd1;
                        state_reg <= S_TSEL;
                    end else begin
                        eb_reg    <= ecur_reg;
                        state_reg <= S_MIX_A;
                    end
                end
                S_MIX_A: begin
                    mul_a_reg     <= {16'd0, mix_m};
                    mul_b_reg     <= {15'd0, ea_reg};
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MIX_A_W;
                end
                S_MIX_A_W: begin
                    if (mul_done) begin
                        acc_reg       <= mul_p[34:0];
                        mul_a_reg     <= {16'd0, 17'(MIX_ONE - mix_m)};
                        mul_b_reg     <= {15'd0, eb_reg};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MIX_B_W;
                    end
                end
                S_MIX_B_W: begin
                    if (mul_done) begin
                        if (!ti_reg[1]) begin
                            dmix_reg  <= mix_sum[32:16];
                            ti_reg    <= ti_reg + 2'd1;
                            state_reg <= S_TSEL;
                        end else begin
                            env_reg   <= $signed({1'b0, dmix_reg})
                                       - $signed({1'b0, mix_sum[32:16]});
                            state_reg <= S_ADV;
                        end
                    end
                end
                S_ADV: begin
                    if (nx_c > loop_length_reg) begin
                        phase_reg <= '0;
                        wrap_reg  <= 1'b1;
                    end else begin
                        phase_reg <= nx_c;
                        wrap_reg  <= 1'b0;
                    end
                    state_reg <= S_OFF;
                end
                S_OFF: begin
                    if (off_sum[48] != off_sum[47]) begin
                        offset_reg <= off_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    end else begin
                        offset_reg <= off_sum[47:0];
                    end
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    if (denom <= 0) begin
                        step_reg  <= 32'hFFFF_FFFF;
                        state_reg <= item_reg ? S_OUT : S_IDLE;
                    end else begin
                        div_dvd_reg       <= STEP_NUM;
                        div_dsr_reg       <= 64'(denom);
                        div_req_reg.count <= DIV_N_STEP;
                        div_req_reg.start <= 1'b1;
                        state_reg         <= S_STEP_W;
                    end
                end
                S_STEP_W: begin
                    if (div_stat.done) begin
                        step_reg  <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                        state_reg <= item_reg ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_env_reg   <= env_reg;
                        item_reg    <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_envelope <= 18'sd65536 && m_envelope >= -18'sd65536))
        else $error("envelope out of range");

    a_phase_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (phase_reg <= loop_length_reg || phase_reg == '0))
        else $error("phase beyond loop length");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/peg_divider.sv =====
// ----------------------------------------------------------------------------
// peg_divider
// Restoring divider, one quotient bit per cycle over a chosen bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module peg_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire peg_pkg::div_req_t         req,
    input  wire logic [peg_pkg::DIV_W-1:0] dividend,
    input  wire logic [peg_pkg::DIV_W-1:0] divisor,
    output logic      [peg_pkg::DIV_W-1:0] quotient,
    output peg_pkg::div_stat_t             stat
);
    import peg_pkg::*;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       rem_s;
    logic [DIV_W:0]       rem_d;
    logic                 fits;

    assign rem_s = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_d = rem_s - {1'b0, dsr_reg};
    assign fits  = rem_s >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
                dvd_reg  <= dividend << (7'd64 - req.count);
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_d[DIV_W-1:0] : rem_s[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;
    assign stat.busy = busy_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/peg_multiplier.sv =====
// ----------------------------------------------------------------------------
// peg_multiplier
// Registered 33 by 32 bit unsigned multiplier with a done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module peg_multiplier (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [32:0] a,
    input  wire logic [31:0] b,
    output logic      [64:0] prod,
    output logic             done
);
    logic [64:0] prod_reg;
    logic        done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
            if (start) begin
                prod_reg <= 65'(a) * 65'(b);
            end
        end
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

`default_nettype wire
